// ----- src/tcs_pkg.sv -----
package tcs_pkg;

  localparam int unsigned MemWords  = 65536;
  localparam int unsigned StackBase = 65280;
  localparam int unsigned AddrW     = $clog2(MemWords);

  typedef struct packed {
    logic        kind;
    logic [15:0] load_address;
    logic [15:0] load_value;
    logic [7:0]  input_char;
    logic [15:0] random_first;
    logic [15:0] random_second;
  } in_t;

  typedef struct packed {
    logic        char_valid;
    logic [7:0]  char_first;
    logic [7:0]  char_second;
    logic        halted;
    logic [15:0] program_counter;
  } out_t;

  typedef enum logic [7:0] {
    OP_NOP = 8'h00, OP_ADD = 8'h01, OP_SUB = 8'h02, OP_MUL = 8'h03,
    OP_DIV = 8'h04, OP_CMP = 8'h05, OP_JMP = 8'h06, OP_GFX = 8'h07,
    OP_AND = 8'h08, OP_NOT = 8'h09, OP_OR  = 8'h0A, OP_XOR = 8'h0B,
    OP_INP = 8'h0C, OP_OUT = 8'h0D, OP_RSH = 8'h0E, OP_LSH = 8'h0F,
    OP_SET = 8'h10, OP_GET = 8'h11, OP_JOZ = 8'h12, OP_RND = 8'h13,
    OP_MOV = 8'h14, OP_PSH = 8'h15, OP_POP = 8'h16, OP_MOD = 8'h17,
    OP_HLT = 8'h18, OP_JNZ = 8'h19, OP_POW = 8'h1A, OP_CAL = 8'h1B,
    OP_RET = 8'h1C
  } op_e;

  localparam logic [3:0] SelPc = 4'd7;
  localparam logic [3:0] SelC  = 4'd9;

  localparam logic [7:0] ModeX   = 8'd1;
  localparam logic [7:0] ModeY   = 8'd2;
  localparam logic [7:0] ModeXY  = 8'd3;
  localparam logic [7:0] ModeYX  = 8'd4;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [15:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quot;
    logic [15:0] rem;
  } div_rsp_t;

endpackage

// ----- src/toy_cpu_instruction_step_unit.sv -----
// Load item: the word is written on accept and the result beat follows from S_OUT.
// Step item: 4 fetch reads, one optional data read, then execute; DIV/MOD wait on the
// radix-2 divider, POW runs square and multiply (two products per exponent bit on the
// shared 16x16 multiplier).
// One item at a time; a stalled result beat holds the input side off.
// Reset (async, active low) clears registers, pc, halt and sets the stack pointer to 255;
// memory contents are undefined until written.
module toy_cpu_instruction_step_unit #(
  parameter int unsigned MemoryWords = tcs_pkg::MemWords,
  parameter int unsigned StkBase     = tcs_pkg::StackBase
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid,
  output logic          in_stall,
  input  tcs_pkg::in_t  in_data_i,
  output logic          out_valid,
  input  logic          out_stall,
  output tcs_pkg::out_t out_data_o,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);
  import tcs_pkg::*;

  localparam int unsigned AW = $clog2(MemoryWords);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_F0   = 11'b00000000010,
    S_F1   = 11'b00000000100,
    S_F2   = 11'b00000001000,
    S_F3   = 11'b00000010000,
    S_OPND = 11'b00000100000,
    S_MEM  = 11'b00001000000,
    S_EXEC = 11'b00010000000,
    S_DIV  = 11'b00100000000,
    S_POW  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  state_e      st_q, st_d;
  in_t         it_q, it_d;
  logic [15:0] gr_q [8];
  logic [15:0] gr_d [8];
  logic [15:0] pc_q, pc_d, start_q, start_d;
  logic [7:0]  sp_q, sp_d;
  logic        halt_q, halt_d;
  logic [15:0] op_q, op_d, ms_q, ms_d, im0_q, im0_d, im1_q, im1_d;
  logic [15:0] d0_q, d0_d, d1_q, d1_d;
  logic [15:0] md_q, md_d;
  logic        ov_q, ov_d;
  out_t        od_q, od_d;
  logic [15:0] pr_q, pr_d, px_q, px_d, pe_q, pe_d;
  logic        pph_q, pph_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [15:0]   wdata, rdata;

  div_req_t dreq;
  div_rsp_t drsp;

  tcs_ram #(.Width(16), .Depth(MemoryWords)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  tcs_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  function automatic logic [15:0] rd_sel(input logic [3:0] s, input logic [15:0] im,
                                         input logic [15:0] pc,
                                         input logic [15:0] g [8]);
    logic [15:0] v;
    if (s <= 4'd6) v = g[s[2:0]];
    else if (s == SelPc) v = pc;
    else if (s == SelC) v = g[7];
    else v = im;
    return v;
  endfunction

  logic [3:0]  s0, s1;
  logic [7:0]  mode;
  logic [15:0] stk_addr_push, stk_addr_pop;
  logic [15:0] res0, res1;
  logic        wr0, wr1, adv;
  logic [31:0] mprod;
  logic [15:0] ma, mb;
  logic [15:0] a0, a1, b0, b1;

  assign s0   = ms_q[7:4];
  assign s1   = ms_q[3:0];
  assign mode = ms_q[15:8];
  assign stk_addr_push = 16'(StkBase) + {8'd0, sp_q};
  assign stk_addr_pop  = 16'(StkBase) + {8'd0, sp_q + 8'd1};
  assign mprod = 32'(ma) * 32'(mb);

  assign in_stall = (st_q != S_IDLE) || (ov_q && out_stall);

  always_comb begin
    st_d = st_q; it_d = it_q; gr_d = gr_q; pc_d = pc_q; start_d = start_q;
    sp_d = sp_q; halt_d = halt_q;
    op_d = op_q; ms_d = ms_q; im0_d = im0_q; im1_d = im1_q;
    d0_d = d0_q; d1_d = d1_q; md_d = md_q;
    ov_d = ov_q && out_stall; od_d = od_q;
    pr_d = pr_q; px_d = px_q; pe_d = pe_q; pph_d = pph_q;
    we = 1'b0; addr = pc_q[AW-1:0]; wdata = '0;
    dreq = '0;
    res0 = '0; res1 = '0; wr0 = 1'b0; wr1 = 1'b0; adv = 1'b1;
    ma = d0_q; mb = d1_q;
    a0 = rd_sel(s0, im0_q, pc_q, gr_q);
    a1 = rd_sel(s1, im1_q, pc_q, gr_q);
    b0 = a0; b1 = a1;

    unique case (st_q)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          it_d = in_data_i;
          if (!in_data_i.kind) begin
            we = 1'b1;
            addr = in_data_i.load_address[AW-1:0];
            wdata = in_data_i.load_value;
            st_d = S_OUT;
          end else if (halt_q) begin
            st_d = S_OUT;
          end else begin
            start_d = pc_q;
            addr = pc_q[AW-1:0];
            st_d = S_F0;
          end
        end
      end
      S_F0: begin
        addr = AW'(start_q + 16'd1);
        st_d = S_F1;
        op_d = rdata;
      end
      S_F1: begin
        addr = AW'(start_q + 16'd2);
        ms_d = rdata;
        st_d = S_F2;
      end
      S_F2: begin
        addr = AW'(start_q + 16'd3);
        im0_d = rdata;
        st_d = S_F3;
      end
      S_F3: begin
        im1_d = rdata;
        st_d = S_OPND;
      end
      S_OPND: begin
        // indexed addressing on the fetched selects
        if (mode == ModeX) b1 = a1 + gr_q[2];
        else if (mode == ModeY) b1 = a1 + gr_q[3];
        else if (mode == ModeXY) begin
          b1 = a1 + gr_q[2]; b0 = a0 + gr_q[3];
        end else if (mode == ModeYX) begin
          b1 = a1 + gr_q[3]; b0 = a0 + gr_q[2];
        end
        d0_d = b0; d1_d = b1;
        pr_d = 16'd1; px_d = b0; pe_d = b1; pph_d = 1'b0;
        st_d = S_EXEC;
        if (op_q == 16'(OP_GET)) begin
          addr = AW'(b0); st_d = S_MEM;
        end else if (op_q == 16'(OP_POP) || op_q == 16'(OP_RET)) begin
          addr = AW'(stk_addr_pop); st_d = S_MEM;
        end else if (op_q == 16'(OP_DIV) || op_q == 16'(OP_MOD)) begin
          dreq.start = 1'b1; dreq.num = b0; dreq.den = b1;
          dreq.is_div = op_q == 16'(OP_DIV);
          st_d = S_DIV;
        end else if (op_q == 16'(OP_POW)) begin
          st_d = S_POW;
        end
      end
      S_MEM: begin
        md_d = rdata;
        st_d = S_EXEC;
      end
      S_DIV: begin
        if (drsp.done) st_d = S_EXEC;
      end
      S_POW: begin
        // alternate: multiply result by base, then square base
        if (pe_q == 16'd0) st_d = S_EXEC;
        else if (!pph_q) begin
          ma = pr_q; mb = px_q;
          if (pe_q[0]) pr_d = mprod[15:0];
          pph_d = 1'b1;
        end else begin
          ma = px_q; mb = px_q;
          px_d = mprod[15:0];
          pe_d = pe_q >> 1;
          pph_d = 1'b0;
        end
      end
      S_EXEC: begin
        ov_d = 1'b0;
        unique case (op_q)
          16'(OP_ADD): begin res0 = d0_q + d1_q; wr0 = 1'b1; end
          16'(OP_SUB): begin res0 = d0_q - d1_q; wr0 = 1'b1; end
          16'(OP_MUL): begin res0 = mprod[15:0]; wr0 = 1'b1; end
          16'(OP_DIV): begin
            res0 = (d1_q == 16'd0) ? 16'hFFFF : drsp.quot; wr0 = 1'b1;
          end
          16'(OP_MOD): begin
            res0 = (d1_q == 16'd0) ? d0_q : drsp.rem; wr0 = 1'b1;
          end
          16'(OP_POW): begin res0 = pr_q; wr0 = 1'b1; end
          16'(OP_CMP): begin
            res1 = (d0_q < d1_q) ? 16'd1 : ((d0_q > d1_q) ? 16'hFFFF : 16'd0);
            wr1 = 1'b1;
          end
          16'(OP_JMP): begin pc_d = d1_q; adv = 1'b0; end
          16'(OP_AND): begin res1 = d1_q & d0_q; wr1 = 1'b1; end
          16'(OP_NOT): begin
            res1 = ~d1_q; res0 = ~d0_q; wr1 = 1'b1; wr0 = 1'b1;
          end
          16'(OP_OR):  begin res1 = d1_q | d0_q; wr1 = 1'b1; end
          16'(OP_XOR): begin res1 = d1_q ^ d0_q; wr1 = 1'b1; end
          16'(OP_INP): begin res1 = {8'd0, it_q.input_char}; wr1 = 1'b1; end
          16'(OP_OUT): begin ov_d = 1'b1; end
          16'(OP_RSH): begin
            res1 = (d0_q >= 16'd16) ? 16'd0 : (d1_q >> d0_q[3:0]); wr1 = 1'b1;
          end
          16'(OP_LSH): begin
            res1 = (d0_q >= 16'd16) ? 16'd0 : (d1_q << d0_q[3:0]); wr1 = 1'b1;
          end
          16'(OP_SET): begin we = 1'b1; addr = AW'(d0_q); wdata = d1_q; end
          16'(OP_GET): begin res1 = md_q; wr1 = 1'b1; end
          16'(OP_JOZ): begin
            if (d0_q == 16'd0) begin pc_d = d1_q; adv = 1'b0; end
          end
          16'(OP_RND): begin
            // second operand wins when both name the same place
            res0 = (s0 == s1) ? it_q.random_second : it_q.random_first;
            res1 = it_q.random_second;
            wr0 = 1'b1; wr1 = 1'b1;
          end
          16'(OP_MOV): begin res1 = d0_q; wr1 = 1'b1; end
          16'(OP_PSH): begin
            we = 1'b1; addr = AW'(stk_addr_push); wdata = d0_q; sp_d = sp_q - 8'd1;
          end
          16'(OP_POP): begin res1 = md_q; wr1 = 1'b1; sp_d = sp_q + 8'd1; end
          16'(OP_HLT): halt_d = 1'b1;
          16'(OP_JNZ): begin
            if (d0_q != 16'd0) begin pc_d = d1_q; adv = 1'b0; end
          end
          16'(OP_CAL): begin
            we = 1'b1; addr = AW'(stk_addr_push); wdata = pc_q + 16'd4;
            sp_d = sp_q - 8'd1; pc_d = d1_q; adv = 1'b0;
          end
          16'(OP_RET): begin pc_d = md_q; sp_d = sp_q + 8'd1; adv = 1'b0; end
          default: ;
        endcase
        // second operand written first, first operand wins on a clash
        if (wr1) begin
          if (s1 <= 4'd6) gr_d[s1[2:0]] = res1;
          else if (s1 == SelPc) pc_d = res1;
          else if (s1 == SelC) gr_d[7] = res1;
        end
        if (wr0) begin
          if (s0 <= 4'd6) gr_d[s0[2:0]] = res0;
          else if (s0 == SelPc) pc_d = res0;
          else if (s0 == SelC) gr_d[7] = res0;
        end
        if ((s0 == SelPc || s1 == SelPc) && pc_d != start_q) adv = 1'b0;
        if (adv) pc_d = pc_d + 16'd4;
        if (pc_d == 16'hFFFF) pc_d = '0;
        od_d.char_valid  = ov_d;
        od_d.char_first  = ov_d ? d0_q[7:0] : 8'd0;
        od_d.char_second = ov_d ? d1_q[7:0] : 8'd0;
        od_d.halted = halt_d;
        od_d.program_counter = pc_d;
        ov_d = 1'b1;
        st_d = S_IDLE;
      end
      S_OUT: begin
        od_d.char_valid = 1'b0; od_d.char_first = '0; od_d.char_second = '0;
        od_d.halted = halt_q; od_d.program_counter = pc_q;
        ov_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    if (cfg_we) sp_d = cfg_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      for (int i = 0; i < 8; i++) gr_q[i] <= '0;
      pc_q <= '0; sp_q <= 8'hFF; halt_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; gr_q <= gr_d; pc_q <= pc_d; sp_q <= sp_d;
      halt_q <= halt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; start_q <= start_d; op_q <= op_d; ms_q <= ms_d;
    im0_q <= im0_d; im1_q <= im1_d; d0_q <= d0_d; d1_q <= d1_d; md_q <= md_d;
    od_q <= od_d; pr_q <= pr_d; px_q <= px_d; pe_q <= pe_d; pph_q <= pph_d;
  end

  assign out_valid  = ov_q;
  assign out_data_o = od_q;

`ifndef ASSERT_OFF
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> in_stall) else $error("input taken while busy");
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halt_q) |-> halt_q) else $error("halt flag cleared");
  a_pc_never_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q != 16'hFFFF) else $error("pc left at top word");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o))
    else $error("stalled result beat changed");
`endif
endmodule

// ----- src/tcs_ram.sv -----
module tcs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- src/tcs_div.sv -----
module tcs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcs_pkg::div_req_t req_i,
  output tcs_pkg::div_rsp_t rsp_o
);
  import tcs_pkg::*;

  logic [15:0] q_q, q_d, r_q, r_d, den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;

  always_comb begin
    q_d = q_q; r_d = r_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {r_q, q_q[15]} - {1'b0, den_q};
    if (req_i.start) begin
      q_d = req_i.num; r_d = '0; den_d = req_i.den;
      cnt_d = 5'd16; busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit a cycle, restoring
      if (!trial[16]) begin
        r_d = trial[15:0];
      end else begin
        r_d = {r_q[14:0], q_q[15]};
      end
      q_d = {q_q[14:0], ~trial[16]};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without busy");
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 5'd0) else $error("divider count ran out while busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done and busy");
`endif
endmodule

// ----- verif/toy_cpu_instruction_step_unit_tb.sv -----
module toy_cpu_instruction_step_unit_tb;
  import tcs_pkg::*;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data_o;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;

  toy_cpu_instruction_step_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_i  (in_data_i),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data_o (out_data_o),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // machine copy
  logic [15:0] regs_m [8];
  logic [15:0] pc_m;
  logic [7:0]  sp_m;
  logic        halt_m;
  logic [15:0] mem_m [MemWords];
  bit          written_m [MemWords];
  logic [15:0] imm_m [2];

  in_t  send_q [$];
  out_t beat_q [$];
  row_t dir_tab [$];

  int unsigned err_cnt, sent_items, step_cnt, out_cnt, char_cnt;
  int unsigned hold_req;
  bit in_taken;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(600000 * 12);
    $display("[toy_cpu_instruction_step_unit] ERROR");
    $finish;
  end

  function automatic logic [15:0] opnd_rd(logic [3:0] sel, int slot);
    if (sel <= 4'd6) return regs_m[sel[2:0]];
    if (sel == SelPc) return pc_m;
    if (sel == SelC) return regs_m[7];
    return imm_m[slot];
  endfunction

  task automatic opnd_wr(logic [3:0] sel, int slot, logic [15:0] v);
    if (sel <= 4'd6) regs_m[sel[2:0]] = v;
    else if (sel == SelPc) pc_m = v;
    else if (sel == SelC) regs_m[7] = v;
    else imm_m[slot] = v;
  endtask

  task automatic mem_wr(logic [15:0] a, logic [15:0] v);
    mem_m[a] = v;
    written_m[a] = 1'b1;
  endtask

  // operands as the step at pc_m would see them
  task automatic fetch_opnds(output logic [15:0] d0, output logic [15:0] d1,
                             output logic [3:0] s0, output logic [3:0] s1);
    logic [15:0] ms;
    logic [7:0]  mode;
    ms = mem_m[pc_m + 16'd1];
    imm_m[0] = mem_m[pc_m + 16'd2];
    imm_m[1] = mem_m[pc_m + 16'd3];
    mode = ms[15:8];
    s0 = ms[7:4];
    s1 = ms[3:0];
    d0 = opnd_rd(s0, 0);
    d1 = opnd_rd(s1, 1);
    case (mode)
      ModeX:  d1 = d1 + regs_m[2];
      ModeY:  d1 = d1 + regs_m[3];
      ModeXY: begin
        d1 = d1 + regs_m[2];
        d0 = d0 + regs_m[3];
      end
      ModeYX: begin
        d1 = d1 + regs_m[3];
        d0 = d0 + regs_m[2];
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pow16(logic [15:0] b, logic [15:0] e);
    logic [31:0] r, x;
    r = 1;
    x = b;
    while (e != 0) begin
      if (e[0]) r = (r * x) & 32'hFFFF;
      x = (x * x) & 32'hFFFF;
      e = e >> 1;
    end
    return r[15:0];
  endfunction

  task automatic step_machine(input in_t it, output out_t r);
    logic [15:0] start, op, d0, d1, sa;
    logic [3:0]  s0, s1;
    bit adv;
    r = '0;
    if (!it.kind) begin
      mem_wr(it.load_address, it.load_value);
    end else if (!halt_m) begin
      start = pc_m;
      op = mem_m[start];
      fetch_opnds(d0, d1, s0, s1);
      adv = 1'b1;
      if (op[15:8] == 8'h00) begin
        case (op_e'(op[7:0]))
          OP_ADD: opnd_wr(s0, 0, d0 + d1);
          OP_SUB: opnd_wr(s0, 0, d0 - d1);
          OP_MUL: opnd_wr(s0, 0, d0 * d1);
          OP_DIV: opnd_wr(s0, 0, (d1 == 0) ? 16'hFFFF : d0 / d1);
          OP_CMP: opnd_wr(s1, 1, (d0 < d1) ? 16'h0001 : ((d0 > d1) ? 16'hFFFF : 16'h0000));
          OP_JMP: begin
            pc_m = d1;
            adv = 1'b0;
          end
          OP_AND: opnd_wr(s1, 1, d1 & d0);
          OP_NOT: begin
            opnd_wr(s1, 1, ~d1);
            opnd_wr(s0, 0, ~d0);
          end
          OP_OR:  opnd_wr(s1, 1, d1 | d0);
          OP_XOR: opnd_wr(s1, 1, d1 ^ d0);
          OP_INP: opnd_wr(s1, 1, {8'h00, it.input_char});
          OP_OUT: begin
            r.char_valid = 1'b1;
            r.char_first = d0[7:0];
            r.char_second = d1[7:0];
          end
          OP_RSH: opnd_wr(s1, 1, (d0 >= 16) ? 16'h0000 : d1 >> d0);
          OP_LSH: opnd_wr(s1, 1, (d0 >= 16) ? 16'h0000 : d1 << d0);
          OP_SET: mem_wr(d0, d1);
          OP_GET: opnd_wr(s1, 1, mem_m[d0]);
          OP_JOZ: if (d0 == 0) begin
            pc_m = d1;
            adv = 1'b0;
          end
          OP_RND: begin
            opnd_wr(s0, 0, it.random_first);
            opnd_wr(s1, 1, it.random_second);
          end
          OP_MOV: opnd_wr(s1, 1, d0);
          OP_PSH: begin
            mem_wr(16'(StackBase) + {8'h00, sp_m}, d0);
            sp_m = sp_m - 8'd1;
          end
          OP_POP: begin
            sp_m = sp_m + 8'd1;
            sa = 16'(StackBase) + {8'h00, sp_m};
            opnd_wr(s1, 1, mem_m[sa]);
          end
          OP_MOD: opnd_wr(s0, 0, (d1 == 0) ? d0 : d0 % d1);
          OP_HLT: halt_m = 1'b1;
          OP_JNZ: if (d0 != 0) begin
            pc_m = d1;
            adv = 1'b0;
          end
          OP_POW: opnd_wr(s0, 0, pow16(d0, d1));
          OP_CAL: begin
            mem_wr(16'(StackBase) + {8'h00, sp_m}, pc_m + 16'd4);
            sp_m = sp_m - 8'd1;
            pc_m = d1;
            adv = 1'b0;
          end
          OP_RET: begin
            sp_m = sp_m + 8'd1;
            pc_m = mem_m[16'(StackBase) + {8'h00, sp_m}];
            adv = 1'b0;
          end
          default: ;
        endcase
      end
      if ((s0 == SelPc || s1 == SelPc) && pc_m != start) adv = 1'b0;
      if (adv) pc_m = pc_m + 16'd4;
      if (pc_m == 16'hFFFF) pc_m = 16'h0000;
    end
    r.halted = halt_m;
    r.program_counter = pc_m;
  endtask

  function automatic in_t mk_item(bit k, logic [15:0] a, logic [15:0] v);
    in_t it;
    it.kind = k;
    it.load_address = a;
    it.load_value = v;
    it.input_char = 8'($urandom);
    it.random_first = 16'($urandom_range(1, 65535));
    it.random_second = 16'($urandom_range(1, 65535));
    return it;
  endfunction

  task automatic queue_item(in_t it, bit typed, out_t res);
    out_t r;
    step_machine(it, r);
    send_q.push_back(it);
    beat_q.push_back(typed ? res : r);
    if (it.kind) step_cnt++;
  endtask

  task automatic load_word(logic [15:0] a, logic [15:0] v);
    queue_item(mk_item(1'b0, a, v), 1'b0, '0);
  endtask

  function automatic logic [15:0] rand_imm();
    return ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
  endfunction

  // place one random instruction at pc, back any data it reads, then run it
  task automatic queue_step(logic [15:0] op);
    logic [15:0] d0, d1, sa;
    logic [3:0]  s0, s1;
    logic [7:0]  mode;
    mode = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 4)) : 8'($urandom);
    load_word(pc_m, op);
    load_word(pc_m + 16'd1, {mode, 4'($urandom), 4'($urandom)});
    load_word(pc_m + 16'd2, rand_imm());
    load_word(pc_m + 16'd3, rand_imm());
    if (!halt_m) begin
      fetch_opnds(d0, d1, s0, s1);
      sa = 16'(StackBase) + {8'h00, sp_m + 8'd1};
      if (op == 16'(OP_GET) && !written_m[d0]) load_word(d0, 16'($urandom));
      if ((op == 16'(OP_POP) || op == 16'(OP_RET)) && !written_m[sa])
        load_word(sa, 16'($urandom));
    end
    queue_item(mk_item(1'b1, 16'($urandom), 16'($urandom)), 1'b0, '0);
  endtask

  function automatic logic [15:0] rand_op();
    logic [15:0] op;
    if ($urandom_range(0, 99) < 8) op = 16'($urandom);
    else op = 16'($urandom_range(0, 28));
    if (op == 16'(OP_HLT)) op = 16'(OP_NOP);
    return op;
  endfunction

  task automatic queue_random(int unsigned n);
    int unsigned lim;
    lim = sent_items + send_q.size() + n;
    while (sent_items + send_q.size() < lim) begin
      if ($urandom_range(0, 9) == 0) load_word(16'($urandom), 16'($urandom));
      else queue_step(rand_op());
    end
  endtask

  task automatic wait_idle();
    while (send_q.size() != 0 || beat_q.size() != 0 || in_valid) @(posedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_sp(logic [7:0] v);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sp_m = v;
  endtask

  // sampling
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && in_valid && !in_stall) in_taken = 1'b1;
    if (rst_ni && out_valid && !out_stall) begin
      out_cnt++;
      if (beat_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        e = beat_q.pop_front();
        if (e.char_valid) char_cnt++;
        if (out_data_o.char_valid !== e.char_valid || out_data_o.char_first !== e.char_first ||
            out_data_o.char_second !== e.char_second || out_data_o.halted !== e.halted ||
            out_data_o.program_counter !== e.program_counter) begin
          err_cnt++;
          if (err_cnt <= 10) $display("beat %0d: expected %p, got %p", out_cnt, e, out_data_o);
        end
      end
    end
  end

  // sender: bursts and gaps
  initial begin
    int unsigned burst, gap;
    bit cur;
    burst = 1;
    gap = 0;
    cur = 1'b0;
    forever begin
      @(negedge clk_i);
      if (in_taken) begin
        in_taken = 1'b0;
        void'(send_q.pop_front());
        sent_items++;
        cur = 1'b0;
      end
      if (!cur && rst_ni) begin
        if (gap > 0) gap--;
        else if (send_q.size() > 0) begin
          cur = 1'b1;
          in_data_i <= send_q[0];
          burst--;
          if (burst == 0) begin
            burst = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= cur;
    end
  end

  // receiver: own stall pattern, plus long holds on request
  initial begin
    int unsigned hold, span, pct;
    hold = 0;
    span = 0;
    pct = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (span == 0) begin
        span = $urandom_range(20, 150);
        pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      end
      span--;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    logic [7:0] sp_set [4];
    for (int i = 0; i < 8; i++) regs_m[i] = '0;
    pc_m = '0;
    sp_m = 8'hFF;
    halt_m = 1'b0;
    imm_m[0] = '0;
    imm_m[1] = '0;
    sp_set[0] = 8'hFF;
    sp_set[1] = 8'h00;
    sp_set[2] = 8'($urandom);
    sp_set[3] = 8'h80;

    // OUT of two immediates, divide by zero, jump near the top, modulo by zero with
    // pc wrap past 0xFFFF, top memory word, then replay of the first instruction
    dir_tab = '{
      '{mk_item(1'b0, 16'h0000, 16'(OP_OUT)), 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 16'h0000}},
      '{mk_item(1'b0, 16'h0001, 16'h0088), 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 16'h0000}},
      '{mk_item(1'b0, 16'h0002, 16'h00FF), 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 16'h0000}},
      '{mk_item(1'b0, 16'h0003, 16'hAB12), 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 16'h0000}},
      '{mk_item(1'b1, 16'hFFFF, 16'h0000), 1'b1, '{1'b1, 8'hFF, 8'h12, 1'b0, 16'h0004}},
      '{mk_item(1'b0, 16'h0004, 16'(OP_DIV)), 1'b0, '0},
      '{mk_item(1'b0, 16'h0005, 16'h0008), 1'b0, '0},
      '{mk_item(1'b0, 16'h0006, 16'h0000), 1'b0, '0},
      '{mk_item(1'b0, 16'h0007, 16'h0000), 1'b0, '0},
      '{mk_item(1'b1, 16'h0000, 16'hFFFF), 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 16'h0008}},
      '{mk_item(1'b0, 16'h0008, 16'(OP_JMP)), 1'b0, '0},
      '{mk_item(1'b0, 16'h0009, 16'h0088), 1'b0, '0},
      '{mk_item(1'b0, 16'h000A, 16'h0000), 1'b0, '0},
      '{mk_item(1'b0, 16'h000B, 16'hFFFB), 1'b0, '0},
      '{mk_item(1'b1, 16'h1234, 16'h5678), 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 16'hFFFB}},
      '{mk_item(1'b0, 16'hFFFB, 16'(OP_MOD)), 1'b0, '0},
      '{mk_item(1'b0, 16'hFFFC, 16'h0008), 1'b0, '0},
      '{mk_item(1'b0, 16'hFFFD, 16'h0000), 1'b0, '0},
      '{mk_item(1'b0, 16'hFFFE, 16'h0000), 1'b0, '0},
      '{mk_item(1'b1, 16'h0000, 16'h0000), 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 16'h0000}},
      '{mk_item(1'b0, 16'hFFFF, 16'hFFFF), 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 16'h0000}},
      '{mk_item(1'b1, 16'h5555, 16'hAAAA), 1'b1, '{1'b1, 8'hFF, 8'h12, 1'b0, 16'h0004}},
      '{mk_item(1'b1, 16'hAAAA, 16'h5555), 1'b0, '0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_sp(sp_set[p]);
      if (p == 0) begin
        foreach (dir_tab[i]) queue_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
      end
      // starve the output for a long stretch so the block backs up
      if (p == 1) hold_req = 400;
      queue_random(310);
      // hold back stimulus until the pipe has drained
      if (p == 2) begin
        while (beat_q.size() != 0) @(posedge clk_i);
        queue_random(20);
      end
    end

    wait_idle();
    queue_step(16'(OP_HLT));
    queue_step(rand_op());
    queue_step(rand_op());
    wait_idle();

    $display("covered %0d items (%0d steps), %0d result beats, %0d OUT beats",
             sent_items, step_cnt, out_cnt, char_cnt);
    $display("four stack pointer settings, long output hold, drain pause, halt at the end");
    if (err_cnt == 0) begin
      $display("[toy_cpu_instruction_step_unit] OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("[toy_cpu_instruction_step_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- toy_cpu_instruction_step_unit.f -----
src/tcs_pkg.sv
src/tcs_ram.sv
src/tcs_div.sv
src/toy_cpu_instruction_step_unit.sv
verif/toy_cpu_instruction_step_unit_tb.sv
